/* design/stepper_ramp_generator_core_assert.svh */
// Assertion macros for the stepper ramp generator core.
// Expect clk and rst_n in scope at the point of use; no other dependencies.
`ifndef STEPPER_RAMP_GENERATOR_CORE_ASSERT_SVH
`define STEPPER_RAMP_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define SRG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SRG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/srg_pkg.sv */
// Shared types and constants for the stepper ramp generator core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srg_pkg;

  localparam int OP_W    = 2;
  localparam int VALUE_W = 32;
  localparam int SA_W    = 48;   // step_angle register width, also divider steps
  localparam int INC_W   = 23;   // accel_increment register width
  localparam int GOAL_W  = 24;   // stored target speed width
  localparam int PER_W   = 32;
  localparam int OPOS_W  = 32;
  localparam int CNT_W   = $clog2(SA_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_ANGLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_INC  = 1'd1;

  localparam logic [SA_W-1:0]  STEP_ANGLE_RST = 48'd73728000;
  localparam logic [INC_W-1:0] ACCEL_INC_RST  = 23'd3108;

  localparam logic signed [VALUE_W-1:0] GOAL_MAX = 32'sd8388607;
  localparam logic signed [VALUE_W-1:0] GOAL_MIN = -32'sd8388608;

  localparam logic [PER_W-1:0] PERIOD_FLOOR_SPEED = 32'd30;
  localparam logic [PER_W-1:0] PERIOD_FLOOR_DIST  = 32'd25;
  localparam logic [PER_W-1:0] PERIOD_MAX         = 32'hFFFF_FFFF;

  // Distance-mode speed used in place of zero is 1/MIN_SPEED_DIV of unity, rounded to nearest
  localparam longint MIN_SPEED_DIV = 1000;

  // How the reported period is formed
  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_MAX  = 2'd1;
  localparam logic [1:0] PK_DIV  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
  } srg_in_t;

  typedef struct packed {
    logic                     stepped;
    logic                     step_level;
    logic                     direction;
    logic [PER_W-1:0]         period_us;
    logic signed [OPOS_W-1:0] position;
  } srg_out_t;

endpackage

`default_nettype wire

/* design/stepper_ramp_generator_core.sv */
// Stepper ramp generator: an accepted request goes from the idle state to the done
// state, or through the divide state first for a step that needs a period.
// No new request is taken until its result is loaded into the output register;
// the period comes from a 48-step restoring divider, one quotient bit per cycle.
// A result held off by out_ready stalls the next request until it is taken.
// Reset (synchronous, rst_n low) restores registers and motion state at once.
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_ramp_generator_core_assert.svh"

module stepper_ramp_generator_core #(
  parameter int SPEED_FRAC_BITS = 16,
  parameter int POSITION_WIDTH  = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  srg_pkg::srg_in_t             in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output srg_pkg::srg_out_t            out_data,
  input  wire                          cfg_we,
  input  wire [srg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [srg_pkg::SA_W-1:0]      cfg_data
);

  import srg_pkg::*;

  localparam int SPD_W = (SPEED_FRAC_BITS + 2 > GOAL_W) ? SPEED_FRAC_BITS + 2 : GOAL_W;
  localparam int SUM_W = SPD_W + 1;
  localparam int PW    = POSITION_WIDTH;
  localparam int DW    = POSITION_WIDTH + 1;

  localparam longint LIMIT_INT = 64'sd3 <<< (SPEED_FRAC_BITS - 1);
  localparam longint MINQ_INT  = ((64'sd1 <<< SPEED_FRAC_BITS) + MIN_SPEED_DIV / 2)
                                 / MIN_SPEED_DIV;
  localparam longint MINQ_SAFE = (MINQ_INT > 0) ? MINQ_INT : 64'sd1;

  localparam logic signed [SUM_W-1:0] SPEED_LIMIT = SUM_W'(LIMIT_INT);
  localparam logic signed [SUM_W-1:0] SPEED_MINQ  = SUM_W'(MINQ_SAFE);
  localparam logic [CNT_W-1:0]        DIV_LAST    = CNT_W'(SA_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [SA_W-1:0]         step_angle_r, step_angle_nxt;
  logic [INC_W-1:0]        accel_r, accel_nxt;
  logic                    dist_mode_r, dist_mode_nxt;
  logic [SPD_W-1:0]        speed_r, speed_nxt;
  logic [GOAL_W-1:0]       goal_r, goal_nxt;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic [PW-1:0]           start_r, start_nxt;
  logic [PW-1:0]           end_r, end_nxt;
  logic [PW-2:0]           ramp_r, ramp_nxt;
  logic                    pulse_r, pulse_nxt;
  logic                    res_step_r, res_step_nxt;
  logic                    res_dir_r, res_dir_nxt;
  logic [1:0]              res_kind_r, res_kind_nxt;
  logic                    res_dist_r, res_dist_nxt;
  logic [SA_W-1:0]         quot_r, quot_nxt;
  logic [SPD_W-1:0]        rem_r, rem_nxt;
  logic [SPD_W-1:0]        mag_r, mag_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  srg_out_t                out_data_r, out_data_nxt;

  logic                    in_accept;
  logic signed [SUM_W-1:0] speed_x, goal_x, inc_x, up_x, dn_x, nx_s, nx_d, nx;
  logic [SUM_W-1:0]        nx_mag;
  logic signed [DW-1:0]    pos_x, start_x, end_x, d_start, d_end, d_move;
  logic [DW-1:0]           done_mag, rest_mag, move_mag, ramp_x;
  logic [PW+VALUE_W-1:0]   tgt_ext;
  logic [PW-1:0]           tgt;
  logic                    dir_s, dir_d;
  logic [SPD_W:0]          div_shift, div_trial;
  logic [OPOS_W+PW-1:0]    pos_out_ext;
  logic [PER_W-1:0]        period_c, floor_c;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Speed, position and target arithmetic for one request
  always_comb begin
    speed_x = $signed({speed_r[SPD_W-1], speed_r});
    goal_x  = $signed({{(SUM_W-GOAL_W){goal_r[GOAL_W-1]}}, goal_r});
    inc_x   = $signed({{(SUM_W-INC_W){1'b0}}, accel_r});
    up_x    = speed_x + inc_x;
    dn_x    = speed_x - inc_x;

    if (speed_x < goal_x) begin
      nx_s = (up_x > goal_x) ? goal_x : up_x;
    end else if (speed_x > goal_x) begin
      nx_s = (dn_x < goal_x) ? goal_x : dn_x;
    end else begin
      nx_s = speed_x;
    end
    dir_s = nx_s[SUM_W-1];

    pos_x    = $signed({pos_r[PW-1], pos_r});
    start_x  = $signed({start_r[PW-1], start_r});
    end_x    = $signed({end_r[PW-1], end_r});
    d_start  = start_x - pos_x;
    d_end    = end_x - pos_x;
    done_mag = d_start[DW-1] ? (~d_start + 1'b1) : d_start;
    rest_mag = d_end[DW-1] ? (~d_end + 1'b1) : d_end;
    ramp_x   = {2'b00, ramp_r};

    // accelerate over the first quarter, brake over the last
    if (done_mag < ramp_x) begin
      nx_d = up_x;
    end else if (rest_mag < ramp_x) begin
      nx_d = dn_x;
    end else begin
      nx_d = speed_x;
    end
    if (nx_d > SPEED_LIMIT) begin
      nx_d = SPEED_LIMIT;
    end
    if (nx_d < -SPEED_LIMIT) begin
      nx_d = -SPEED_LIMIT;
    end
    if (nx_d == '0) begin
      nx_d = SPEED_MINQ;
    end
    dir_d = !d_end[DW-1] && (d_end != '0);

    nx     = dist_mode_r ? nx_d : nx_s;
    nx_mag = nx[SUM_W-1] ? (~nx + 1'b1) : nx;

    tgt_ext  = {{PW{in_data.value[VALUE_W-1]}}, in_data.value};
    tgt      = tgt_ext[PW-1:0];
    d_move   = $signed({tgt[PW-1], tgt}) - pos_x;
    move_mag = d_move[DW-1] ? (~d_move + 1'b1) : d_move;

    div_shift = {rem_r, quot_r[SA_W-1]};
    div_trial = div_shift - {1'b0, mag_r};

    floor_c = res_dist_r ? PERIOD_FLOOR_DIST : PERIOD_FLOOR_SPEED;
    if (quot_r[SA_W-1:PER_W] != '0) begin
      period_c = PERIOD_MAX;
    end else if (quot_r[PER_W-1:0] < floor_c) begin
      period_c = floor_c;
    end else begin
      period_c = quot_r[PER_W-1:0];
    end

    pos_out_ext = {{OPOS_W{pos_r[PW-1]}}, pos_r};
  end

  // Sequencer, divider and output register
  always_comb begin
    state_nxt      = state_r;
    step_angle_nxt = step_angle_r;
    accel_nxt      = accel_r;
    dist_mode_nxt  = dist_mode_r;
    speed_nxt      = speed_r;
    goal_nxt       = goal_r;
    pos_nxt        = pos_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    ramp_nxt       = ramp_r;
    pulse_nxt      = pulse_r;
    res_step_nxt   = res_step_r;
    res_dir_nxt    = res_dir_r;
    res_kind_nxt   = res_kind_r;
    res_dist_nxt   = res_dist_r;
    quot_nxt       = quot_r;
    rem_nxt        = rem_r;
    mag_nxt        = mag_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_ANGLE: step_angle_nxt = cfg_data;
        REG_ACCEL_INC:  accel_nxt      = cfg_data[INC_W-1:0];
        default:        step_angle_nxt = step_angle_r;
      endcase
    end

    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_step_nxt = 1'b0;
          res_dir_nxt  = 1'b0;
          res_kind_nxt = PK_NONE;
          res_dist_nxt = dist_mode_r;
          state_nxt    = ST_DONE;
          case (in_data.operation)
            OP_RUN: begin
              if (in_data.value > GOAL_MAX) begin
                goal_nxt = GOAL_MAX[GOAL_W-1:0];
              end else if (in_data.value < GOAL_MIN) begin
                goal_nxt = GOAL_MIN[GOAL_W-1:0];
              end else begin
                goal_nxt = in_data.value[GOAL_W-1:0];
              end
              dist_mode_nxt = 1'b0;
            end
            OP_MOVE: begin
              start_nxt     = pos_r;
              end_nxt       = tgt;
              ramp_nxt      = move_mag[DW-1:2];
              dist_mode_nxt = 1'b1;
            end
            OP_TICK: begin
              // at the target in distance mode: no step
              if (!dist_mode_r || rest_mag != '0) begin
                speed_nxt    = nx[SPD_W-1:0];
                res_step_nxt = 1'b1;
                res_dir_nxt  = dist_mode_r ? dir_d : dir_s;
                pulse_nxt    = !pulse_r;
                if (dist_mode_r ? dir_d : !dir_s) begin
                  pos_nxt = pos_r + 1'b1;
                end else begin
                  pos_nxt = pos_r - 1'b1;
                end
                if (nx_mag == '0) begin
                  res_kind_nxt = PK_MAX;
                end else begin
                  res_kind_nxt = PK_DIV;
                  quot_nxt     = step_angle_r;
                  rem_nxt      = '0;
                  mag_nxt      = nx_mag[SPD_W-1:0];
                  cnt_nxt      = '0;
                  state_nxt    = ST_DIV;
                end
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle, dividend shifts out as quotient shifts in
        quot_nxt = {quot_r[SA_W-2:0], !div_trial[SPD_W]};
        rem_nxt  = div_trial[SPD_W] ? div_shift[SPD_W-1:0] : div_trial[SPD_W-1:0];
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.stepped    = res_step_r;
          out_data_nxt.step_level = pulse_r;
          out_data_nxt.direction  = res_dir_r;
          out_data_nxt.position   = $signed(pos_out_ext[OPOS_W-1:0]);
          case (res_kind_r)
            PK_MAX:  out_data_nxt.period_us = PERIOD_MAX;
            PK_DIV:  out_data_nxt.period_us = period_c;
            default: out_data_nxt.period_us = '0;
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_angle_r <= STEP_ANGLE_RST;
      accel_r      <= ACCEL_INC_RST;
      dist_mode_r  <= 1'b0;
      speed_r      <= '0;
      goal_r       <= '0;
      pos_r        <= '0;
      start_r      <= '0;
      end_r        <= '0;
      ramp_r       <= '0;
      pulse_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_angle_r <= step_angle_nxt;
      accel_r      <= accel_nxt;
      dist_mode_r  <= dist_mode_nxt;
      speed_r      <= speed_nxt;
      goal_r       <= goal_nxt;
      pos_r        <= pos_nxt;
      start_r      <= start_nxt;
      end_r        <= end_nxt;
      ramp_r       <= ramp_nxt;
      pulse_r      <= pulse_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_step_r <= res_step_nxt;
    res_dir_r  <= res_dir_nxt;
    res_kind_r <= res_kind_nxt;
    res_dist_r <= res_dist_nxt;
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    mag_r      <= mag_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  `SRG_ASSERT_IMP(a_div_nonzero, state_r == ST_DIV, mag_r != '0, "divide by zero speed")
  `SRG_ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(state_r == ST_DONE),
                  "result loaded outside done state")
  `SRG_ASSERT_NXT(a_speed_tick_toggles,
                  in_accept && (in_data.operation == OP_TICK) && !dist_mode_r,
                  pulse_r != $past(pulse_r), "speed-mode tick did not step")

endmodule

`default_nettype wire
